[design/ctf_pkg.sv]
`timescale 1ns / 1ps

package ctf_pkg;

   // payload widths
   localparam int CARD_BYTE_W = 8;
   localparam int OUT_W       = 10;

   // default text capacity
   localparam int TEXT_CAP_DEFAULT = 768;

   // window and prefix table sizes
   localparam int WIN_LEN      = 12;
   localparam int WIN_W        = WIN_LEN * CARD_BYTE_W;
   localparam int LEN_W        = $clog2(WIN_LEN + 1);
   localparam int NUM_PREFIXES = 24;

   // special byte codes
   localparam logic [CARD_BYTE_W-1:0] BYTE_STOP     = 8'hFE;
   localparam logic [CARD_BYTE_W-1:0] BYTE_EMPTY    = 8'h00;
   localparam logic [CARD_BYTE_W-1:0] BYTE_FILL     = 8'hFF;
   localparam logic [CARD_BYTE_W-1:0] PRINT_LO      = 8'd32;
   localparam logic [CARD_BYTE_W-1:0] PRINT_HI      = 8'd126;
   localparam logic [CARD_BYTE_W-1:0] HIGH_CHAR_LO  = 8'd128;

   // prefix text is right-aligned: last character in the low byte
   typedef struct packed {
      logic [WIN_W-1:0] text;
      logic [LEN_W-1:0] len;
   } prefix_type;

   // the coin removal prefix spells its underscore as an octal escape
   localparam prefix_type PREFIXES [NUM_PREFIXES] = '{
      '{text: "GET:SPC_TXT:", len: 4'd12},
      '{text: "GET:TARGET",   len: 4'd10},
      '{text: "GET:TGT",      len: 4'd7},
      '{text: "GET:SYNC",     len: 4'd8},
      '{text: "GET:LANG",     len: 4'd8},
      '{text: "GET:INFO",     len: 4'd8},
      '{text: "TGT_ADD:",     len: 4'd8},
      '{text: "TGT_DEL:",     len: 4'd8},
      '{text: "TGT_SET:",     len: 4'd8},
      '{text: "TXT:",         len: 4'd4},
      '{text: "ALM_DEL:",     len: 4'd8},
      '{text: "ALM:",         len: 4'd4},
      '{text: "POM:",         len: 4'd4},
      '{text: "SCH_HID:",     len: 4'd8},
      '{text: "SCH_DEL:",     len: 4'd8},
      '{text: "SCH:",         len: 4'd4},
      '{text: "PRE_DEL:ZH:",  len: 4'd11},
      '{text: "PRE_DEL:EN:",  len: 4'd11},
      '{text: "PRE:ZH:",      len: 4'd7},
      '{text: "PRE:EN:",      len: 4'd7},
      '{text: "WIFI:",        len: 4'd5},
      '{text: "COIN\137DEL:", len: 4'd9},
      '{text: "COIN:",        len: 4'd5},
      '{text: "SPC:",         len: 4'd4}
   };

   // byte mask covering the newest len characters of the window
   function automatic logic [WIN_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [WIN_W-1:0] m;
      m = '0;
      for (int i = 0; i < WIN_LEN; i++) begin
         if (i < int'(len)) begin
            m[i*CARD_BYTE_W +: CARD_BYTE_W] = '1;
         end
      end
      return m;
   endfunction

endpackage

[design/ctf_if.sv]
`timescale 1ns / 1ps

interface ctf_req_if import ctf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CARD_BYTE_W-1:0] card_byte;
   logic                   last_byte;

   modport source (output valid, output card_byte, output last_byte, input ready);
   modport sink   (input valid, input card_byte, input last_byte, output ready);
endinterface

interface ctf_rsp_if import ctf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [OUT_W-1:0] command_start;
   logic [OUT_W-1:0] text_length;

   modport source (output valid, output found, output command_start,
                   output text_length, input ready);
   modport sink   (input valid, input found, input command_start,
                   input text_length, output ready);
endinterface

[design/card_text_command_finder.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload                                 Transfer
// req       in   card_byte[7:0], last_byte               req.valid & req.ready
// rsp       out  found, command_start[9:0], text_length  rsp.valid & rsp.ready
//
// One byte per cycle while req.ready is high: the prefix compare against
// the window is a single pass between the state registers and the result register.
// A result appears the cycle after the last-marked byte transfers.
// Reset (synchronous, active high) clears the window, count, stop and match flags, best start and the result valid.
// req.ready drops only while a result is held and rsp.ready is low.

module card_text_command_finder import ctf_pkg::*; #(
   parameter int TEXT_CAP = TEXT_CAP_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   ctf_req_if.sink   req,
   ctf_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(TEXT_CAP + 1);

   logic [WIN_W-1:0] win_ff,   win_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             stop_ff,  stop_in;
   logic             match_ff, match_in;
   logic [CNT_W-1:0] best_ff,  best_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [OUT_W-1:0] rsp_start_ff, rsp_start_in;
   logic [OUT_W-1:0] rsp_len_ff,   rsp_len_in;

   logic             accept;
   logic             take_char;
   logic             printable;
   logic [WIN_W-1:0] win_next;
   logic [CNT_W-1:0] count_next;
   logic [WIN_LEN:1] hit_len;
   logic [LEN_W-1:0] top_len;
   logic [CNT_W-1:0] cand_start;
   logic             new_best;

   // accept while the result register is free or being drained
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // classify the incoming byte
   assign printable = ((req.card_byte >= PRINT_LO) && (req.card_byte <= PRINT_HI))
                      || (req.card_byte >= HIGH_CHAR_LO);
   assign take_char = accept && !stop_ff
                      && (req.card_byte != BYTE_STOP)
                      && (req.card_byte != BYTE_EMPTY)
                      && (req.card_byte != BYTE_FILL)
                      && printable
                      && (count_ff < CNT_W'(TEXT_CAP));

   assign win_next   = {win_ff[WIN_W-CARD_BYTE_W-1:0], req.card_byte};
   assign count_next = count_ff + CNT_W'(1);

   // compare every prefix against the shifted window
   always_comb begin
      hit_len = '0;
      for (int k = 0; k < NUM_PREFIXES; k++) begin
         if (((win_next & prefix_mask(PREFIXES[k].len)) == PREFIXES[k].text)
             && (count_next >= CNT_W'(PREFIXES[k].len))) begin
            hit_len[PREFIXES[k].len] = 1'b1;
         end
      end
   end

   // longest hit gives the earliest start
   always_comb begin
      top_len = '0;
      for (int l = 1; l <= WIN_LEN; l++) begin
         if (hit_len[l]) begin
            top_len = LEN_W'(l);
         end
      end
   end

   assign cand_start = count_next - CNT_W'(top_len);
   assign new_best   = take_char && (|hit_len) && (!match_ff || (cand_start < best_ff));

   // next tag state and result
   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      stop_in  = stop_ff;
      match_in = match_ff;
      best_in  = best_ff;
      if (accept && !stop_ff && (req.card_byte == BYTE_STOP)) begin
         stop_in = 1'b1;
      end
      if (take_char) begin
         win_in   = win_next;
         count_in = count_next;
      end
      if (new_best) begin
         match_in = 1'b1;
         best_in  = cand_start;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      if (accept && req.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = match_in;
         rsp_start_in = match_in ? OUT_W'(best_in) : '0;
         rsp_len_in   = OUT_W'(count_in);
         // clear for the next tag
         win_in   = '0;
         count_in = '0;
         stop_in  = 1'b0;
         match_in = 1'b0;
         best_in  = '0;
      end
   end

   // hold control and tag state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         count_ff     <= '0;
         stop_ff      <= 1'b0;
         match_ff     <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         count_ff     <= count_in;
         stop_ff      <= stop_in;
         match_ff     <= match_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.found         = rsp_found_ff;
   assign rsp.command_start = rsp_start_ff;
   assign rsp.text_length   = rsp_len_ff;

endmodule
